// ===== hw/rtl/ffpn_pkg.sv =====
package ffpn_pkg;

  // fixed-point formats
  localparam int UNIT_FRAC_BITS = 14;
  localparam int AXIS_W         = 16;
  localparam int POINT_W        = 32;
  localparam int THR_W          = 15;
  localparam logic [THR_W-1:0] THR_RESET = 15'd14746;

  // projection and normalisation widths
  localparam int PROD_W  = 32;
  localparam int MAG_W   = 31;
  localparam int NRM_W   = 30;
  localparam int SQ_W    = 2 * NRM_W;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int NUM_W   = ROOT_W + AXIS_W - 1;
  localparam int QUO_W   = AXIS_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int LSH_W   = 5;

  localparam int IN_W  = 3 * POINT_W + 3 * AXIS_W;
  localparam int OUT_W = 9 * AXIS_W + 3 * POINT_W;

  // per-request context carried alongside the arithmetic
  typedef struct packed {
    logic [POINT_W-1:0] px;
    logic [POINT_W-1:0] py;
    logic [POINT_W-1:0] pz;
    logic [AXIS_W-1:0]  nx;
    logic [AXIS_W-1:0]  ny;
    logic [AXIS_W-1:0]  nz;
    logic               sel;
  } ctx_t;

  typedef struct packed {
    ctx_t                        ctx;
    logic                        zero;
    logic [2:0]                  neg;
    logic [2:0][NRM_W-1:0]       mag;
  } carry_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  rad;
  } sqrt_t;

  typedef struct packed {
    ctx_t       ctx;
    logic       zero;
    logic [2:0] neg;
  } dcarry_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0] rem;
    logic [2:0][QUO_W-1:0] quo;
    logic [ROOT_W-1:0]     len;
  } div_t;

  // index of the highest set bit, zero for an empty word
  function automatic logic [LSH_W-1:0] msb_pos(input logic [NRM_W-1:0] v);
    logic [LSH_W-1:0] pos;
    pos = '0;
    for (int i = 0; i < NRM_W; i++) begin
      if (v[i]) pos = LSH_W'(i);
    end
    return pos;
  endfunction

endpackage

// ===== hw/rtl/frame_from_point_normal_unit.sv =====
// frame_from_point_normal_unit
// builds an orthonormal frame from a surface point and a unit normal.
// input channel s_axis: one request per point, carrying the point (Q16.16)
// and the normal (Q1.14). output channel m_axis: the frame x, y and z axes
// (Q1.14) and the origin, which is the point passed through.
// cfg_wen_i / cfg_wdata_i write the alignment threshold on |normal x|; write
// it only while no request is in flight. below the threshold the x axis comes
// from projecting global X, otherwise the y axis from projecting global Y.
// throughput: one request per cycle, sustained while m_axis_tready is high.
// the pipeline depth is set by the 31-step square root and the 16-step
// divider, each one register stage per result bit.
// the whole pipeline advances on one enable: when the receiver stalls with a
// result waiting, every stage holds and s_axis_tready drops in that cycle.
// reset clears all valid bits and loads the threshold with 0.90.
module frame_from_point_normal_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wen_i,
  input  logic [ffpn_pkg::THR_W-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // point_x, point_y, point_z, normal_x, normal_y, normal_z
  input  logic [ffpn_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // xaxis_x/y/z, yaxis_x/y/z, zaxis_x/y/z, origin_x/y/z
  output logic [ffpn_pkg::OUT_W-1:0] m_axis_tdata
);
  import ffpn_pkg::*;

  localparam logic signed [PROD_W-1:0] ONE_SQ = PROD_W'(1) <<< (2 * UNIT_FRAC_BITS);
  localparam logic [QUO_W-1:0] ONE_Q = QUO_W'(1) << UNIT_FRAC_BITS;
  localparam logic [20:0] HALF_R = 21'(1) << (UNIT_FRAC_BITS - 1);

  logic en;
  logic [THR_W-1:0] thr_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_wen_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // stage 1: choose construction, products n[k] * n[i]
  logic [2:0][AXIS_W-1:0] n_in;
  logic [AXIS_W:0]        ax;
  logic                   sel_in;
  logic [AXIS_W-1:0]      nk;
  logic signed [PROD_W-1:0] prod_d [3];
  logic signed [PROD_W-1:0] p1_prod_q [3];
  ctx_t p1_ctx_q;
  logic p1_v_q;

  always_comb begin
    n_in[0] = s_axis_tdata[3*POINT_W +: AXIS_W];
    n_in[1] = s_axis_tdata[3*POINT_W+AXIS_W +: AXIS_W];
    n_in[2] = s_axis_tdata[3*POINT_W+2*AXIS_W +: AXIS_W];
    ax = n_in[0][AXIS_W-1] ? (AXIS_W+1)'(-$signed({n_in[0][AXIS_W-1], n_in[0]}))
                           : {1'b0, n_in[0]};
    sel_in = ax < (AXIS_W+1)'(thr_q);
    nk = sel_in ? n_in[0] : n_in[1];
    for (int i = 0; i < 3; i++) begin
      prod_d[i] = $signed(nk) * $signed(n_in[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p1_v_q <= 1'b0;
    else if (en) p1_v_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_prod_q    <= prod_d;
      p1_ctx_q.px  <= s_axis_tdata[0 +: POINT_W];
      p1_ctx_q.py  <= s_axis_tdata[POINT_W +: POINT_W];
      p1_ctx_q.pz  <= s_axis_tdata[2*POINT_W +: POINT_W];
      p1_ctx_q.nx  <= n_in[0];
      p1_ctx_q.ny  <= n_in[1];
      p1_ctx_q.nz  <= n_in[2];
      p1_ctx_q.sel <= sel_in;
    end
  end

  // stage 2: projected vector, sign and magnitude
  logic signed [PROD_W-1:0] vec [3];
  logic [2:0][MAG_W-1:0] mag_d;
  logic [2:0]            neg_d;
  logic [2:0][MAG_W-1:0] p2_mag_q;
  logic [2:0]            p2_neg_q;
  ctx_t p2_ctx_q;
  logic p2_v_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vec[i] = -p1_prod_q[i];
      if ((i == 0 && p1_ctx_q.sel) || (i == 1 && !p1_ctx_q.sel)) vec[i] = vec[i] + ONE_SQ;
      neg_d[i] = vec[i][PROD_W-1];
      mag_d[i] = neg_d[i] ? MAG_W'(-vec[i]) : MAG_W'(vec[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p2_v_q <= 1'b0;
    else if (en) p2_v_q <= p1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_mag_q <= mag_d;
      p2_neg_q <= neg_d;
      p2_ctx_q <= p1_ctx_q;
    end
  end

  // stage 3: largest magnitude
  logic [MAG_W-1:0] mx_d;
  logic [MAG_W-1:0] p3_mx_q;
  logic [2:0][MAG_W-1:0] p3_mag_q;
  logic [2:0] p3_neg_q;
  ctx_t p3_ctx_q;
  logic p3_v_q;

  always_comb begin
    mx_d = p2_mag_q[0];
    if (p2_mag_q[1] > mx_d) mx_d = p2_mag_q[1];
    if (p2_mag_q[2] > mx_d) mx_d = p2_mag_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p3_v_q <= 1'b0;
    else if (en) p3_v_q <= p2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_mx_q  <= mx_d;
      p3_mag_q <= p2_mag_q;
      p3_neg_q <= p2_neg_q;
      p3_ctx_q <= p2_ctx_q;
    end
  end

  // stage 4: normalising shift amount
  logic p4_rsh_q;
  logic [LSH_W-1:0] p4_lsh_q;
  logic p4_zero_q;
  logic [2:0][MAG_W-1:0] p4_mag_q;
  logic [2:0] p4_neg_q;
  ctx_t p4_ctx_q;
  logic p4_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p4_v_q <= 1'b0;
    else if (en) p4_v_q <= p3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_rsh_q  <= p3_mx_q[MAG_W-1];
      p4_lsh_q  <= LSH_W'(NRM_W - 1) - msb_pos(p3_mx_q[NRM_W-1:0]);
      p4_zero_q <= (p3_mx_q == '0);
      p4_mag_q  <= p3_mag_q;
      p4_neg_q  <= p3_neg_q;
      p4_ctx_q  <= p3_ctx_q;
    end
  end

  // stage 5: shift magnitudes so the largest lies in [2^29, 2^30)
  carry_t p5_q;
  logic p5_v_q;
  logic [2:0][NRM_W-1:0] nrm_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm_d[i] = p4_rsh_q ? NRM_W'(p4_mag_q[i] >> 1) : NRM_W'(p4_mag_q[i] << p4_lsh_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p5_v_q <= 1'b0;
    else if (en) p5_v_q <= p4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_q.ctx  <= p4_ctx_q;
      p5_q.zero <= p4_zero_q;
      p5_q.neg  <= p4_neg_q;
      p5_q.mag  <= nrm_d;
    end
  end

  // stage 6: squares
  logic [2:0][SQ_W-1:0] p6_sq_q;
  carry_t p6_q;
  logic p6_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p6_v_q <= 1'b0;
    else if (en) p6_v_q <= p5_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) p6_sq_q[i] <= p5_q.mag[i] * p5_q.mag[i];
      p6_q <= p5_q;
    end
  end

  // stage 7 and square root: sum of squares, then one root bit per stage
  sqrt_t  sr_q [SQRT_STEPS+1];
  carry_t sc_q [SQRT_STEPS+1];
  logic [SQRT_STEPS:0] sv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sv_q[0] <= 1'b0;
    else if (en) sv_q[0] <= p6_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_q[0].rem  <= '0;
      sr_q[0].root <= '0;
      sr_q[0].rad  <= SUM_W'(p6_sq_q[0]) + SUM_W'(p6_sq_q[1]) + SUM_W'(p6_sq_q[2]);
      sc_q[0]      <= p6_q;
    end
  end

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    sqrt_t nxt;

    always_comb begin
      rem2  = {sr_q[g].rem[REM_W-3:0], sr_q[g].rad[SUM_W-1 -: 2]};
      trial = REM_W'({sr_q[g].root, 2'b01});
      nxt.rad = {sr_q[g].rad[SUM_W-3:0], 2'b00};
      if (rem2 >= trial) begin
        nxt.rem  = rem2 - trial;
        nxt.root = {sr_q[g].root[ROOT_W-2:0], 1'b1};
      end else begin
        nxt.rem  = rem2;
        nxt.root = {sr_q[g].root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) sv_q[g+1] <= 1'b0;
      else if (en) sv_q[g+1] <= sv_q[g];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_q[g+1] <= nxt;
        sc_q[g+1] <= sc_q[g];
      end
    end
  end

  // divider: numerator set-up with rounding, then one quotient bit per stage
  div_t    dq_q [DIV_STEPS+1];
  dcarry_t dc_q [DIV_STEPS+1];
  logic [DIV_STEPS:0] dv_q;
  logic [ROOT_W-1:0] len;

  assign len = sr_q[SQRT_STEPS].root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else if (en) dv_q[0] <= sv_q[SQRT_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dq_q[0].rem[i] <= NUM_W'({sc_q[SQRT_STEPS].mag[i], {UNIT_FRAC_BITS{1'b0}}})
                        + NUM_W'(len >> 1);
      end
      dq_q[0].quo   <= '0;
      dq_q[0].len   <= len;
      dc_q[0].ctx   <= sc_q[SQRT_STEPS].ctx;
      dc_q[0].zero  <= sc_q[SQRT_STEPS].zero;
      dc_q[0].neg   <= sc_q[SQRT_STEPS].neg;
    end
  end

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    localparam int B = QUO_W - 1 - g;
    logic [NUM_W-1:0] dvs;
    div_t nxt;

    always_comb begin
      dvs = NUM_W'(dq_q[g].len) << B;
      nxt = dq_q[g];
      for (int i = 0; i < 3; i++) begin
        if (dq_q[g].rem[i] >= dvs) begin
          nxt.rem[i]    = dq_q[g].rem[i] - dvs;
          nxt.quo[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[g+1] <= 1'b0;
      else if (en) dv_q[g+1] <= dv_q[g];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dq_q[g+1] <= nxt;
        dc_q[g+1] <= dc_q[g];
      end
    end
  end

  // clamp, restore sign, zero a null projection: the projected unit axis
  logic [2:0][AXIS_W-1:0] ax_d;
  logic [2:0][AXIS_W-1:0] pa_q;
  ctx_t pa_ctx_q;
  logic pa_v_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ax_d[i] = (dq_q[DIV_STEPS].quo[i] > ONE_Q) ? ONE_Q : dq_q[DIV_STEPS].quo[i];
      if (dc_q[DIV_STEPS].neg[i]) ax_d[i] = AXIS_W'(-$signed(ax_d[i]));
      if (dc_q[DIV_STEPS].zero) ax_d[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pa_v_q <= 1'b0;
    else if (en) pa_v_q <= dv_q[DIV_STEPS];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q     <= ax_d;
      pa_ctx_q <= dc_q[DIV_STEPS].ctx;
    end
  end

  // cross product n x a: six products
  logic signed [PROD_W-1:0] cp_q [6];
  logic [2:0][AXIS_W-1:0] pc_a_q;
  ctx_t pc_ctx_q;
  logic pc_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pc_v_q <= 1'b0;
    else if (en) pc_v_q <= pa_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp_q[0]  <= $signed(pa_ctx_q.ny) * $signed(pa_q[2]);
      cp_q[1]  <= $signed(pa_ctx_q.nz) * $signed(pa_q[1]);
      cp_q[2]  <= $signed(pa_ctx_q.nz) * $signed(pa_q[0]);
      cp_q[3]  <= $signed(pa_ctx_q.nx) * $signed(pa_q[2]);
      cp_q[4]  <= $signed(pa_ctx_q.nx) * $signed(pa_q[1]);
      cp_q[5]  <= $signed(pa_ctx_q.ny) * $signed(pa_q[0]);
      pc_a_q   <= pa_q;
      pc_ctx_q <= pa_ctx_q;
    end
  end

  // differences rounded half away from zero, sign flip for the y-based frame
  logic signed [PROD_W:0] dif [3];
  logic [PROD_W:0]        dmag [3];
  logic [20:0]            rnd [3];
  logic [AXIS_W-1:0]      rc [3];
  logic [2:0][AXIS_W-1:0] cr_d;
  logic [2:0][AXIS_W-1:0] xa_d;
  logic [2:0][AXIS_W-1:0] ya_d;
  logic [OUT_W-1:0]       tdata_d;
  logic                   out_v_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif[i]  = (PROD_W+1)'(cp_q[2*i]) - (PROD_W+1)'(cp_q[2*i+1]);
      dmag[i] = dif[i][PROD_W] ? (PROD_W+1)'(-dif[i]) : (PROD_W+1)'(dif[i]);
      rnd[i]  = 21'((dmag[i] + (PROD_W+1)'(HALF_R)) >> UNIT_FRAC_BITS);
      rc[i]   = (rnd[i] > 21'(ONE_Q)) ? ONE_Q : AXIS_W'(rnd[i]);
      cr_d[i] = (dif[i][PROD_W] ^ !pc_ctx_q.sel) ? AXIS_W'(-$signed(rc[i])) : rc[i];
      xa_d[i] = pc_ctx_q.sel ? pc_a_q[i] : cr_d[i];
      ya_d[i] = pc_ctx_q.sel ? cr_d[i] : pc_a_q[i];
    end
    tdata_d = {pc_ctx_q.pz, pc_ctx_q.py, pc_ctx_q.px,
               pc_ctx_q.nz, pc_ctx_q.ny, pc_ctx_q.nx,
               ya_d[2], ya_d[1], ya_d[0],
               xa_d[2], xa_d[1], xa_d[0]};
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= pc_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) m_axis_tdata <= tdata_d;
  end

  assign m_axis_tvalid = out_v_q;

  // checks
  a_len_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sv_q[SQRT_STEPS] && !sc_q[SQRT_STEPS].zero) |-> (len[ROOT_W-1:ROOT_W-2] != 2'b00))
    else $error("vector length below normalised range");

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dv_q[DIV_STEPS] && !dc_q[DIV_STEPS].zero) |->
      (dq_q[DIV_STEPS].quo[0] <= ONE_Q && dq_q[DIV_STEPS].quo[1] <= ONE_Q &&
       dq_q[DIV_STEPS].quo[2] <= ONE_Q))
    else $error("normalised component above one");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(sv_q) && $stable(dv_q)))
    else $error("pipeline moved while stalled");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import ffpn_pkg::*;

  localparam int LATENCY = 58;

  // one frame as it leaves the block: nine axis components then the origin
  typedef struct packed {
    logic [2:0][POINT_W-1:0] org;
    logic [8:0][AXIS_W-1:0]  axis;
  } frame_t;

  // one directed request, with the frame typed in where it is obvious
  typedef struct {
    logic [THR_W-1:0] thr;
    int               nx, ny, nz;
    logic             known;
    int               ax[6];
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_wen_i = 1'b0;
  logic [THR_W-1:0]    cfg_wdata_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;

  logic [THR_W-1:0]    thr_model = THR_RESET;
  frame_t              frames_due[$];
  int                  errors = 0;
  int                  cycle_no = 0;
  int                  rx_mode = 0;

  string axis_names[9] = '{"xaxis_x", "xaxis_y", "xaxis_z", "yaxis_x", "yaxis_y",
                           "yaxis_z", "zaxis_x", "zaxis_y", "zaxis_z"};
  string org_names[3] = '{"origin_x", "origin_y", "origin_z"};

  frame_from_point_normal_unit dut (.*);

  always #10 clk_i = ~clk_i;

  // integer square root, floor
  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint round_shift(longint v);
    if (v < 0) return -((-v + (64'sd1 << (UNIT_FRAC_BITS - 1))) >>> UNIT_FRAC_BITS);
    return (v + (64'sd1 << (UNIT_FRAC_BITS - 1))) >>> UNIT_FRAC_BITS;
  endfunction

  function automatic longint clamp_unit(longint v);
    longint one;
    one = 64'sd1 << UNIT_FRAC_BITS;
    if (v > one) v = one;
    if (v < -one) v = -one;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // global axis k projected onto the plane of n, then normalised
  task automatic plane_axis(input int k, input longint n[3], output longint a[3]);
    longint unsigned mag[3], mx, sum, len, q;
    logic neg[3];
    longint v;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      v = -(n[k] * n[i]);
      if (i == k) v += 64'sd1 << (2 * UNIT_FRAC_BITS);
      neg[i] = v < 0;
      mag[i] = neg[i] ? -v : v;
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      a = '{0, 0, 0};
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      mx = mx >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx = mx << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << UNIT_FRAC_BITS) + (len >> 1)) / len;
      if (q > (64'd1 << UNIT_FRAC_BITS)) q = 64'd1 << UNIT_FRAC_BITS;
      a[i] = neg[i] ? -longint'(q) : longint'(q);
    end
  endtask

  task automatic cross_unit(input longint u[3], input longint w[3], output longint r[3]);
    r[0] = round_shift(u[1] * w[2] - u[2] * w[1]);
    r[1] = round_shift(u[2] * w[0] - u[0] * w[2]);
    r[2] = round_shift(u[0] * w[1] - u[1] * w[0]);
  endtask

  // frame predicted for one request under the current threshold
  task automatic predict_frame(input logic [IN_W-1:0] req, output frame_t f);
    longint n[3], xa[3], ya[3], anx;
    for (int i = 0; i < 3; i++) n[i] = longint'($signed(req[3*POINT_W + i*AXIS_W +: AXIS_W]));
    anx = n[0] < 0 ? -n[0] : n[0];
    if (anx < longint'(thr_model)) begin
      plane_axis(0, n, xa);
      cross_unit(n, xa, ya);
    end else begin
      plane_axis(1, n, ya);
      cross_unit(ya, n, xa);
    end
    for (int i = 0; i < 3; i++) begin
      f.axis[i]     = AXIS_W'(clamp_unit(xa[i]));
      f.axis[3 + i] = AXIS_W'(clamp_unit(ya[i]));
      f.axis[6 + i] = req[3*POINT_W + i*AXIS_W +: AXIS_W];
      f.org[i]      = req[i*POINT_W +: POINT_W];
    end
  endtask

  function automatic logic [IN_W-1:0] pack_req(int nx, int ny, int nz);
    return {AXIS_W'(nz), AXIS_W'(ny), AXIS_W'(nx), $urandom(), $urandom(), $urandom()};
  endfunction

  // offer one request and wait until it is taken
  task automatic send_req(input logic [IN_W-1:0] req, input logic known, input int ax[6]);
    frame_t f;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frame(req, f);
    if (known) for (int i = 0; i < 6; i++) f.axis[i] = AXIS_W'(ax[i]);
    frames_due.insert(frames_due.size(), f);
    @(negedge clk_i);
  endtask

  task automatic hold_off(int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  // drain the pipeline, then load a new threshold
  task automatic write_threshold(logic [THR_W-1:0] thr);
    s_axis_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
    cfg_wen_i   <= 1'b1;
    cfg_wdata_i <= thr;
    @(negedge clk_i);
    cfg_wen_i <= 1'b0;
    thr_model = thr;
  endtask

  function automatic int pick_axis_comp();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 32768) - 16384;
    if (r < 8) return $urandom_range(0, 600) - 300;
    if (r < 9) return ($urandom_range(0, 1) ? 16384 : -16384) - $urandom_range(0, 40)
                      * ($urandom_range(0, 1) ? 1 : -1);
    return int'($signed(16'($urandom())));
  endfunction

  // receiver stalls: a mode chosen at random, always ready, mostly ready or bursty
  always @(negedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no % 64 == 0) rx_mode <= $urandom_range(0, 2);
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 3) != 0;
      default: m_axis_tready <= (cycle_no % 11) < 6;
    endcase
  end

  // compare each frame with the oldest one due
  always @(posedge clk_i) begin
    frame_t got, due;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (frames_due.size() == 0) begin
        $error("frame with no request outstanding");
        errors++;
      end else begin
        due = frames_due.pop_front();
        for (int i = 0; i < 9; i++)
          if (got.axis[i] !== due.axis[i]) begin
            $error("%s: expected %0d, got %0d", axis_names[i],
                   $signed(due.axis[i]), $signed(got.axis[i]));
            errors++;
          end
        for (int i = 0; i < 3; i++)
          if (got.org[i] !== due.org[i]) begin
            $error("%s: expected %0d, got %0d", org_names[i],
                   $signed(due.org[i]), $signed(got.org[i]));
            errors++;
          end
      end
    end
  end

  // stimulus
  initial begin
    row_t rows[$];
    int phase_thr[6];
    int nx, ny, nz, burst;
    // directed: axis normals, zero normal, zero projection, threshold edges
    rows.insert(rows.size(), '{THR_RESET, 0, 0, 16384, 1, '{16384, 0, 0, 0, 16384, 0}});
    rows.insert(rows.size(), '{THR_RESET, 16384, 0, 0, 1, '{0, 0, -16384, 0, 16384, 0}});
    rows.insert(rows.size(), '{THR_RESET, 0, 0, 0, 1, '{16384, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{THR_RESET, 0, 16384, 0, 0, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{THR_RESET, 0, 0, -16384, 0, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{THR_RESET, -16384, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{THR_RESET, 14745, 7000, 0, 0, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{THR_RESET, 14746, 7000, 0, 0, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{THR_RESET, -14746, 0, 7000, 0, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{THR_RESET, 9459, 9459, 9459, 0, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{THR_RESET, -32768, 32767, -32768, 0, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{THR_RESET, 32767, -32768, 32767, 0, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{THR_RESET, 11585, -11585, 0, 0, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{15'd32767, 16384, 0, 0, 1, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{15'd32767, -16384, 0, 0, 1, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{15'd32767, 0, 16384, 0, 0, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{15'd0, 0, 0, 16384, 0, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{15'd0, 0, 16384, 0, 0, '{0, 0, 0, 0, 0, 0}});
    rows.insert(rows.size(), '{15'd0, 0, 0, 0, 0, '{0, 0, 0, 0, 0, 0}});
    phase_thr = '{0, 16384, 32767, 14746, 1, -1};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[r]) begin
      if (rows[r].thr != thr_model) write_threshold(rows[r].thr);
      send_req(pack_req(rows[r].nx, rows[r].ny, rows[r].nz), rows[r].known, rows[r].ax);
      hold_off($urandom_range(0, 2));
    end

    // random phases, each under its own threshold
    foreach (phase_thr[p]) begin
      write_threshold(phase_thr[p] < 0 ? THR_W'($urandom_range(0, 16384)) : THR_W'(phase_thr[p]));
      for (int i = 0; i < 165; ) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst; b++, i++) begin
          nx = pick_axis_comp();
          if ($urandom_range(0, 4) == 0)
            nx = ($urandom_range(0, 1) ? 1 : -1) * (int'(thr_model) + $urandom_range(0, 2) - 1);
          ny = pick_axis_comp();
          nz = pick_axis_comp();
          send_req(pack_req(nx, ny, nz), 1'b0, '{0, 0, 0, 0, 0, 0});
        end
        if (i > 80 && i <= 80 + burst) begin
          // let the pipeline run dry mid phase
          s_axis_tvalid <= 1'b0;
          while (frames_due.size() != 0) @(negedge clk_i);
        end else if ($urandom_range(0, 3) != 0) begin
          hold_off($urandom_range(1, 8));
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0) $display("frame_from_point_normal_unit test passed");
    else $display("frame_from_point_normal_unit test failed");
    $finish;
  end

  // run limit
  initial begin
    #4ms;
    $display("frame_from_point_normal_unit test failed");
    $finish;
  end

endmodule
